// ----- hw/rtl/cdtmc_pkg.sv -----
// package for the countdown timer mode controller
// holds the event and mode codes, register indexes and the payload structs
// no dependencies
`default_nettype none

package cdtmc_pkg;

	// event kinds carried in the func field
	typedef enum logic [2:0] {
		FUNC_WAKE   = 3'd0,
		FUNC_PRESS  = 3'd1,
		FUNC_LONG   = 3'd2,
		FUNC_ROTATE = 3'd3,
		FUNC_TICK   = 3'd4
	} func_t;

	// controller modes
	typedef enum logic [2:0] {
		MODE_SLEEP  = 3'd0,
		MODE_WAKING = 3'd1,
		MODE_SET    = 3'd2,
		MODE_COUNT  = 3'd3,
		MODE_ALERT  = 3'd4,
		MODE_PROMPT = 3'd5,
		MODE_CALIB  = 3'd6
	} mode_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_WAKE_TIMEOUT  = 3'd0,
		REG_SET_TIMEOUT   = 3'd1,
		REG_ALERT_TIMEOUT = 3'd2,
		REG_CALIB_TIMEOUT = 3'd3,
		REG_BLINK_PERIOD  = 3'd4,
		REG_BLINK_ON      = 3'd5,
		REG_MAX_SET       = 3'd6,
		REG_CALIB_DETENTS = 3'd7
	} reg_idx_t;

	localparam int CFG_W = 16;

	// reset values of the configuration registers
	localparam logic [15:0] WAKE_TIMEOUT_RST  = 16'd4;
	localparam logic [15:0] SET_TIMEOUT_RST   = 16'd480;
	localparam logic [15:0] ALERT_TIMEOUT_RST = 16'd960;
	localparam logic [15:0] CALIB_TIMEOUT_RST = 16'd240;
	localparam logic [15:0] BLINK_PERIOD_RST  = 16'd32;
	localparam logic [15:0] BLINK_ON_RST      = 16'd1;
	localparam logic [6:0]  MAX_SET_RST       = 7'd120;
	localparam logic [7:0]  CALIB_DETENTS_RST = 8'd36;

	// reset value of the set minutes and the ceiling of the under-zero count
	localparam logic [6:0] SET_MINUTES_RST = 7'd25;
	localparam logic [8:0] UNDER_ZERO_MAX  = 9'd511;

	// one input event
	typedef struct packed {
		logic [2:0]        func;
		logic signed [7:0] delta;
	} item_t;

	// one result
	typedef struct packed {
		mode_t       mode;
		logic [6:0]  set_value;
		logic [6:0]  remaining;
		logic        led_lit;
		logic        display_enabled;
		logic [15:0] minute_length;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/countdown_timer_mode_controller.sv -----
// countdown timer mode controller: one event in, one result out
// an event passes the input register, then the result register; one event per cycle
// while the result is not stalled; the state update runs between these two
// registers, so the next event always sees the updated state
// asynchronous active-low reset: sleep mode, 25 set minutes, registers at their defaults
// depends on cdtmc_pkg
`default_nettype none

module countdown_timer_mode_controller
	import cdtmc_pkg::*;
#(
	parameter int TICKS_PER_SECOND = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire item_t              item,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output result_t                 result,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	localparam logic [15:0] TPM_RST = 16'((60 * TICKS_PER_SECOND) & 16'hFFFF);

	// configuration registers
	logic [15:0] wake_to_q, set_to_q, alert_to_q, calib_to_q;
	logic [15:0] blink_period_q, blink_on_q;
	logic [6:0]  max_set_q;
	logic [7:0]  calib_detents_q;

	// controller state
	mode_t       mode_q, mode_d;
	logic [6:0]  set_min_q, set_min_d;
	logic [6:0]  left_q, left_d;
	logic [15:0] idle_q, idle_d;
	logic [15:0] blink_q, blink_d;
	logic [8:0]  uzt_q, uzt_d;
	logic [15:0] tpm_q, tpm_d;
	logic        led_q, led_d;
	logic        disp_q, disp_d;

	// pipeline registers
	logic        valid_s1;
	item_t       item_s1;
	logic        advance;
	logic        commit;

	// scratch values for the update
	logic [15:0]       idle_inc;
	logic signed [9:0] sum;
	logic [9:0]        uzt_sum;
	logic [8:0]        uzt_new;
	logic [16:0]       blink_nxt;
	logic [6:0]        left_tick;

	// handshake: the result register frees up when empty or taken
	assign advance    = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign commit     = valid_s1 && advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wake_to_q       <= WAKE_TIMEOUT_RST;
			set_to_q        <= SET_TIMEOUT_RST;
			alert_to_q      <= ALERT_TIMEOUT_RST;
			calib_to_q      <= CALIB_TIMEOUT_RST;
			blink_period_q  <= BLINK_PERIOD_RST;
			blink_on_q      <= BLINK_ON_RST;
			max_set_q       <= MAX_SET_RST;
			calib_detents_q <= CALIB_DETENTS_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_WAKE_TIMEOUT:  wake_to_q       <= cfg_data;
				REG_SET_TIMEOUT:   set_to_q        <= cfg_data;
				REG_ALERT_TIMEOUT: alert_to_q      <= cfg_data;
				REG_CALIB_TIMEOUT: calib_to_q      <= cfg_data;
				REG_BLINK_PERIOD:  blink_period_q  <= cfg_data;
				REG_BLINK_ON:      blink_on_q      <= cfg_data;
				REG_MAX_SET:       max_set_q       <= cfg_data[6:0];
				REG_CALIB_DETENTS: calib_detents_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// shared arithmetic
	assign idle_inc  = (idle_q == 16'hFFFF) ? 16'hFFFF : idle_q + 16'd1;
	assign sum       = $signed({3'b000, set_min_q}) + 10'(item_s1.delta);
	assign uzt_sum   = {1'b0, uzt_q} + 10'(-sum);
	assign blink_nxt = {1'b0, blink_q} + 17'd1;

	// next state
	always_comb begin
		mode_d    = mode_q;
		set_min_d = set_min_q;
		left_d    = left_q;
		idle_d    = idle_q;
		blink_d   = blink_q;
		uzt_d     = uzt_q;
		tpm_d     = tpm_q;
		led_d     = led_q;
		disp_d    = disp_q;
		uzt_new   = uzt_q;
		left_tick = left_q;
		case (func_t'(item_s1.func))
			FUNC_WAKE: begin
				if (mode_q == MODE_SLEEP) begin
					idle_d = '0;
					mode_d = MODE_WAKING;
				end
			end
			FUNC_PRESS: begin
				case (mode_q)
					MODE_WAKING: begin
						disp_d = 1'b1;
						idle_d = '0;
						uzt_d  = '0;
						mode_d = MODE_SET;
					end
					MODE_SET: begin
						left_d = set_min_q;
						idle_d = '0;
						mode_d = MODE_COUNT;
					end
					MODE_ALERT: begin
						led_d  = 1'b0;
						idle_d = '0;
						uzt_d  = '0;
						mode_d = MODE_SET;
					end
					MODE_PROMPT: begin
						idle_d = '0;
						mode_d = MODE_CALIB;
					end
					MODE_CALIB: begin
						tpm_d  = idle_q;
						idle_d = '0;
						uzt_d  = '0;
						mode_d = MODE_SET;
					end
					default: ;
				endcase
			end
			FUNC_LONG: begin
				disp_d = 1'b0;
				led_d  = 1'b0;
				mode_d = MODE_SLEEP;
			end
			FUNC_ROTATE: begin
				if (mode_q == MODE_SET) begin
					// wide sum, shortfall below zero feeds the calibration count
					if (sum < 0) begin
						uzt_new   = (uzt_sum > 10'(UNDER_ZERO_MAX)) ? UNDER_ZERO_MAX
							: uzt_sum[8:0];
						set_min_d = '0;
					end else if (sum[7:0] > {1'b0, max_set_q}) begin
						uzt_new   = '0;
						set_min_d = max_set_q;
					end else begin
						uzt_new   = '0;
						set_min_d = sum[6:0];
					end
					uzt_d  = uzt_new;
					idle_d = '0;
					if (uzt_new >= {1'b0, calib_detents_q}) begin
						mode_d = MODE_PROMPT;
					end
				end
			end
			FUNC_TICK: begin
				case (mode_q)
					MODE_WAKING: begin
						idle_d = idle_inc;
						if (idle_inc >= wake_to_q) begin
							disp_d = 1'b0;
							led_d  = 1'b0;
							mode_d = MODE_SLEEP;
						end
					end
					MODE_SET: begin
						idle_d = idle_inc;
						if (idle_inc >= set_to_q) begin
							disp_d = 1'b0;
							led_d  = 1'b0;
							mode_d = MODE_SLEEP;
						end
					end
					MODE_COUNT: begin
						// minute boundary, floor at zero
						idle_d = idle_inc;
						if (idle_inc >= tpm_q) begin
							if (left_q != '0) begin
								left_tick = left_q - 7'd1;
							end
							idle_d = '0;
						end
						left_d = left_tick;
						if (left_tick == '0) begin
							blink_d = '0;
							idle_d  = '0;
							mode_d  = MODE_ALERT;
						end
					end
					MODE_ALERT: begin
						// blink cycle
						if (blink_q == '0) begin
							led_d = 1'b1;
						end else if (blink_q == blink_on_q) begin
							led_d = 1'b0;
						end
						blink_d = (blink_nxt >= {1'b0, blink_period_q}) ? '0
							: blink_nxt[15:0];
						idle_d = idle_inc;
						if (idle_inc >= alert_to_q) begin
							led_d  = 1'b0;
							idle_d = '0;
							uzt_d  = '0;
							mode_d = MODE_SET;
						end
					end
					MODE_PROMPT: begin
						idle_d = idle_inc;
						if (idle_inc >= calib_to_q) begin
							disp_d = 1'b0;
							led_d  = 1'b0;
							mode_d = MODE_SLEEP;
						end
					end
					MODE_CALIB: begin
						idle_d = idle_inc;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// state registers, updated on each event that moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SLEEP;
			set_min_q <= SET_MINUTES_RST;
			left_q    <= '0;
			idle_q    <= '0;
			blink_q   <= '0;
			uzt_q     <= '0;
			tpm_q     <= TPM_RST;
			led_q     <= 1'b0;
			disp_q    <= 1'b0;
		end else if (commit) begin
			mode_q    <= mode_d;
			set_min_q <= set_min_d;
			left_q    <= left_d;
			idle_q    <= idle_d;
			blink_q   <= blink_d;
			uzt_q     <= uzt_d;
			tpm_q     <= tpm_d;
			led_q     <= led_d;
			disp_q    <= disp_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result.mode            <= mode_d;
			result.set_value       <= set_min_d;
			result.remaining       <= left_d;
			result.led_lit         <= led_d;
			result.display_enabled <= disp_d;
			result.minute_length   <= tpm_d;
		end
	end

endmodule

`default_nettype wire
